[hdl/swbi_pkg.sv]
// shared types and constants for the stack with bottom increment unit
// no dependencies; used by swbi_cell and the top level
`default_nettype none

package swbi_pkg;

  // number of cells in the chain, one stored entry each
  localparam int unsigned StkDepth = 1024;
  localparam int unsigned IdxW     = $clog2(StkDepth);
  localparam int unsigned CntW     = $clog2(StkDepth + 1);

  // fixed field widths
  localparam int unsigned DataW = 32;
  localparam int unsigned SizeW = 11;
  localparam int unsigned OpW   = 2;

  localparam logic [SizeW-1:0] MaxSizeReset = SizeW'(1024);
  localparam logic [DataW-1:0] EmptyValue   = '1;

  typedef enum logic [OpW-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_INC  = 2'd2
  } op_e;

  // contents of one cell: stored value and its lazy increment
  typedef struct packed {
    logic [DataW-1:0] entry;
    logic [DataW-1:0] pend;
  } cell_data_t;

  // per-cell control for one cycle
  typedef struct packed {
    logic push;
    logic pop;
    logic inc;
  } cell_ctl_t;

endpackage

`default_nettype wire

[hdl/swbi_cell.sv]
// one cell of the stack chain: holds one entry and its pending increment
// depends on swbi_pkg
`default_nettype none

module swbi_cell (
  input  logic                      clk_i,
  input  swbi_pkg::cell_ctl_t       ctl_i,
  input  swbi_pkg::cell_data_t      above_i,
  input  swbi_pkg::cell_data_t      below_i,
  input  logic [swbi_pkg::DataW-1:0] amt_i,
  output swbi_pkg::cell_data_t      data_o
);
  import swbi_pkg::*;

  cell_data_t data_d, data_q;

  // push shifts down from above, pop shifts up from below, increment adds in place
  always_comb begin
    data_d = data_q;
    priority if (ctl_i.push) begin
      data_d = above_i;
    end else if (ctl_i.pop) begin
      data_d = below_i;
    end else if (ctl_i.inc) begin
      data_d.pend = data_q.pend + amt_i;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[hdl/stack_with_bottom_increment_unit.sv]
// top level of the stack with bottom increment unit: chain of cells, fill
// counter, capacity register and result register; depends on swbi_pkg, swbi_cell
//
//   channel | signals                              | direction
//   input   | in_valid_i/in_ready_o, 4 fields      | request in
//   result  | out_valid_o/out_ready_i, 2 fields    | request out
//   config  | cfg_valid_i/cfg_ready_o, max_size_i  | register write in
//
// cell 0 always holds the top of stack, so a pop reads it directly while the whole
// chain shifts up in the same cycle
// a push shifts the chain down; an increment adds into the one addressed cell
// reset clears the fill count and the result valid and sets the capacity register to 1024;
// cell contents need no clearing as a pushed cell always starts with zero increment
// a stalled result blocks new requests until it is taken
`default_nettype none

module stack_with_bottom_increment_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [swbi_pkg::OpW-1:0]    opcode_i,
  input  logic signed [swbi_pkg::DataW-1:0] push_value_i,
  input  logic [swbi_pkg::SizeW-1:0]  bottom_count_i,
  input  logic signed [swbi_pkg::DataW-1:0] add_amount_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [swbi_pkg::DataW-1:0] popped_value_o,
  output logic                        was_empty_o,
  // configuration channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [swbi_pkg::SizeW-1:0]  max_size_i
);
  import swbi_pkg::*;

  logic [SizeW-1:0] max_size_d, max_size_q;
  logic [CntW-1:0]  fill_d, fill_q;
  logic             out_valid_d, out_valid_q;
  logic [DataW-1:0] out_value_d, out_value_q;
  logic             out_empty_d, out_empty_q;

  logic             accept;
  logic             do_push, do_pop, do_inc, is_pop;
  logic             fill_zero;
  logic [31:0]      k_clamped;
  logic [31:0]      target_wide;
  logic [IdxW-1:0]  target;

  cell_data_t       cell_q    [StkDepth];
  cell_data_t       cell_above[StkDepth];
  cell_data_t       cell_below[StkDepth];
  cell_ctl_t        cell_ctl  [StkDepth];
  cell_data_t       top_pop_src;

  // handshakes
  assign accept      = in_valid_i & in_ready_o;
  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign cfg_ready_o = 1'b1;

  // command decode
  assign fill_zero = (fill_q == '0);

  always_comb begin
    do_push = 1'b0;
    do_pop  = 1'b0;
    do_inc  = 1'b0;
    is_pop  = 1'b0;
    unique case (opcode_i)
      OP_PUSH: do_push = accept && (32'(fill_q) < 32'(max_size_q))
                         && (32'(fill_q) < 32'(StkDepth));
      OP_POP: begin
        is_pop = accept;
        do_pop = accept & ~fill_zero;
      end
      OP_INC:  do_inc = accept && !fill_zero && (bottom_count_i != '0);
      default: ;
    endcase
  end

  // cell holding entry k-1 counted from the bottom sits at fill-k from the top
  assign k_clamped   = (32'(bottom_count_i) > 32'(fill_q)) ? 32'(fill_q)
                                                           : 32'(bottom_count_i);
  assign target_wide = 32'(fill_q) - k_clamped;
  assign target      = target_wide[IdxW-1:0];

  // popping the top folds its increment into the next cell down
  assign top_pop_src.entry = cell_q[1].entry;
  assign top_pop_src.pend  = cell_q[1].pend + cell_q[0].pend;

  // neighbour wiring and per-cell control
  always_comb begin
    for (int i = 0; i < StkDepth; i++) begin
      if (i == 0) begin
        cell_above[i].entry = push_value_i;
        cell_above[i].pend  = '0;
        cell_below[i]       = top_pop_src;
      end else begin
        cell_above[i] = cell_q[i-1];
        cell_below[i] = (i == StkDepth - 1) ? cell_q[i] : cell_q[(i+1) % StkDepth];
      end
      cell_ctl[i].push = do_push;
      cell_ctl[i].pop  = do_pop;
      cell_ctl[i].inc  = do_inc && (target == IdxW'(i));
    end
  end

  // chain of cells, index 0 is the top of stack
  for (genvar g = 0; g < StkDepth; g++) begin : g_cell
    swbi_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[g]),
      .above_i (cell_above[g]),
      .below_i (cell_below[g]),
      .amt_i   (add_amount_i),
      .data_o  (cell_q[g])
    );
  end

  // fill count
  always_comb begin
    fill_d = fill_q;
    priority if (do_push) begin
      fill_d = fill_q + CntW'(1);
    end else if (do_pop) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  // capacity register
  assign max_size_d = (cfg_valid_i & cfg_ready_o) ? max_size_i : max_size_q;

  // result register
  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    out_value_d = out_value_q;
    out_empty_d = out_empty_q;
    if (is_pop) begin
      out_valid_d = 1'b1;
      out_value_d = fill_zero ? EmptyValue : (cell_q[0].entry + cell_q[0].pend);
      out_empty_d = fill_zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      max_size_q  <= MaxSizeReset;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      max_size_q  <= max_size_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_empty_q <= out_empty_d;
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_value_q;
  assign was_empty_o    = out_empty_q;

endmodule

`default_nettype wire
